// ----- hdl/ipuv_pkg.sv -----
// Package for the IPv4/UDP packet validator: verdict codes, stage records,
// protocol constants and the one's-complement adder.
// No dependencies; every other file of the block but ipuv_if imports it.
package ipuv_pkg;

  // Protocol constants.
  localparam logic [15:0] IP_MIN_HDR  = 16'd20;
  localparam logic [15:0] UDP_HDR_LEN = 16'd8;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] MAX_COUNT   = 16'hFFFF;
  localparam logic [15:0] SUM_ONES    = 16'hFFFF;

  // Verdict codes.
  typedef enum logic [3:0] {
    RSN_GOOD   = 4'd0,
    RSN_SHORT  = 4'd1,
    RSN_HDRLEN = 4'd2,
    RSN_TOTLEN = 4'd3,
    RSN_IPSUM  = 4'd4,
    RSN_PROTO  = 4'd5,
    RSN_UDPLEN = 4'd6,
    RSN_PORT   = 4'd7,
    RSN_FRAG   = 4'd8,
    RSN_UDPSUM = 4'd9,
    RSN_TRUNC  = 4'd10
  } reason_t;

  // Packet state gathered while bytes stream in; also the snapshot at the last byte.
  typedef struct packed {
    logic [15:0] count;
    logic [3:0]  ihl;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [15:0] frag;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] hsum;
    logic [15:0] dsum;
    logic [15:0] udp_len;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        sum_present;
    logic [7:0]  pending;
  } pkt_state_t;

  // Intermediate verdict handed from the check stage to the result stage.
  typedef struct packed {
    reason_t     reason;
    logic        sum_present;
    logic [15:0] part_a;
    logic [15:0] part_b;
    logic [15:0] payload_length;
    logic [6:0]  payload_offset;
    logic [31:0] dest_addr;
    logic [31:0] src_addr;
    logic [15:0] src_port;
  } chk_res_t;

  // Final result record.
  typedef struct packed {
    logic        accepted;
    reason_t     reason;
    logic [15:0] payload_length;
    logic [6:0]  payload_offset;
    logic [31:0] dest_addr;
    logic [31:0] src_addr;
    logic [15:0] src_port;
  } out_res_t;

  // 16-bit one's-complement add with end-around carry.
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ----- hdl/ipuv_if.sv -----
// Valid/ready channel interfaces for the packet byte stream and the verdict.
// No dependencies.
interface ipuv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ipuv_out_if;
  logic        valid;
  logic        ready;
  logic        accepted;
  logic [3:0]  reason;
  logic [15:0] payload_length;
  logic [6:0]  payload_offset;
  logic [31:0] dest_addr;
  logic [31:0] src_addr;
  logic [15:0] src_port;

  modport source (output valid, output accepted, output reason, output payload_length,
                  output payload_offset, output dest_addr, output src_addr,
                  output src_port, input ready);
  modport sink (input valid, input accepted, input reason, input payload_length,
                input payload_offset, input dest_addr, input src_addr,
                input src_port, output ready);
endinterface

// ----- hdl/ipuv_byte_parser.sv -----
// Byte parser: captures header fields and running checksums per byte, and
// hands a snapshot of the packet state onward at the last byte.
// Depends on ipuv_pkg and ipuv_if.
module ipuv_byte_parser
  import ipuv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ipuv_in_if.sink    in_chan,
  output logic       snap_valid,
  input  logic       snap_ready,
  output pkt_state_t snap
);

  pkt_state_t  state_r;
  pkt_state_t  state_nxt;
  pkt_state_t  snap_r;
  logic        snap_v_r;
  logic        accept;
  logic [15:0] off;
  logic [7:0]  b;
  logic [5:0]  hlen;
  logic [15:0] rel;
  logic        in_hdr;
  logic        in_udp;
  logic [15:0] word;

  assign in_chan.ready = !snap_v_r || snap_ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign off           = state_r.count;
  assign b             = in_chan.data_byte;

  // Per-byte field capture and checksum update.
  always_comb begin
    state_nxt = state_r;
    hlen      = {state_r.ihl, 2'b00};
    rel       = '0;
    in_hdr    = 1'b0;
    in_udp    = 1'b0;
    word      = {state_r.pending, b};
    if (state_r.count != MAX_COUNT) begin
      state_nxt.count = state_r.count + 16'd1;
      if (off == 16'd0) begin
        state_nxt.ihl = b[3:0];
      end
      hlen = {state_nxt.ihl, 2'b00};
      if (off == 16'd2 || off == 16'd3) begin
        state_nxt.total_len = {state_r.total_len[7:0], b};
      end
      if (off == 16'd6 || off == 16'd7) begin
        state_nxt.frag = {state_r.frag[7:0], b};
      end
      if (off == 16'd9) begin
        state_nxt.proto = b;
      end
      if (off >= 16'd12 && off <= 16'd15) begin
        state_nxt.src = {state_r.src[23:0], b};
      end
      if (off >= 16'd16 && off <= 16'd19) begin
        state_nxt.dst = {state_r.dst[23:0], b};
      end
      in_hdr = off < {10'd0, hlen};
      rel    = off - {10'd0, hlen};
      if (!in_hdr) begin
        if (rel == 16'd0 || rel == 16'd1) begin
          state_nxt.sport = {state_r.sport[7:0], b};
        end
        if (rel == 16'd2 || rel == 16'd3) begin
          state_nxt.dport = {state_r.dport[7:0], b};
        end
        if (rel == 16'd4 || rel == 16'd5) begin
          state_nxt.udp_len = {state_r.udp_len[7:0], b};
        end
        if ((rel == 16'd6 || rel == 16'd7) && b != 8'd0) begin
          state_nxt.sum_present = 1'b1;
        end
        in_udp = (rel < 16'd6) || (rel < state_nxt.udp_len);
      end
      // Even bytes wait for their partner; odd bytes complete a word.
      if (in_hdr || in_udp) begin
        if (!off[0]) begin
          state_nxt.pending = b;
        end else if (in_hdr) begin
          state_nxt.hsum = oc_add(state_r.hsum, word);
        end else begin
          state_nxt.dsum = oc_add(state_r.dsum, word);
        end
      end
    end
  end

  // Packet state and snapshot valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= '0;
      snap_v_r <= 1'b0;
    end else begin
      if (snap_v_r && snap_ready) begin
        snap_v_r <= 1'b0;
      end
      if (accept) begin
        if (in_chan.last_byte) begin
          state_r  <= '0;
          snap_v_r <= 1'b1;
        end else begin
          state_r <= state_nxt;
        end
      end
    end
  end

  // Snapshot payload.
  always_ff @(posedge clk) begin
    if (accept && in_chan.last_byte) begin
      snap_r <= state_nxt;
    end
  end

  assign snap_valid = snap_v_r;
  assign snap       = snap_r;

endmodule

// ----- hdl/ipuv_check.sv -----
// Check stage: runs the ordered header checks on a packet snapshot and forms
// two partial sums of the UDP checksum over the pseudo-header and the datagram.
// Depends on ipuv_pkg.
module ipuv_check
  import ipuv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] local_port,
  input  logic        snap_valid,
  output logic        snap_ready,
  input  pkt_state_t  snap,
  output logic        chk_valid,
  input  logic        chk_ready,
  output chk_res_t    chk
);

  chk_res_t    chk_r;
  chk_res_t    chk_nxt;
  logic        chk_v_r;
  logic [5:0]  hlen;
  logic [6:0]  hlen_udp;
  logic [16:0] udp_end;
  logic [15:0] tail;

  assign snap_ready = !chk_v_r || chk_ready;
  assign hlen       = {snap.ihl, 2'b00};
  assign hlen_udp   = {1'b0, hlen} + 7'(UDP_HDR_LEN);
  assign udp_end    = {1'b0, snap.udp_len} + {11'd0, hlen};
  assign tail       = snap.udp_len[0] ? {snap.pending, 8'd0} : 16'd0;

  // Ordered checks; the first failure sets the reason.
  always_comb begin
    chk_nxt                = '0;
    chk_nxt.sum_present    = snap.sum_present;
    chk_nxt.part_a         = oc_add(oc_add(snap.src[31:16], snap.src[15:0]),
                                    oc_add(snap.dst[31:16], snap.dst[15:0]));
    chk_nxt.part_b         = oc_add(oc_add(snap.dsum, tail),
                                    oc_add({8'd0, snap.proto}, snap.udp_len));
    chk_nxt.payload_length = snap.udp_len - UDP_HDR_LEN;
    chk_nxt.payload_offset = hlen_udp;
    chk_nxt.dest_addr      = snap.dst;
    chk_nxt.src_addr       = snap.src;
    chk_nxt.src_port       = snap.sport;
    if (snap.count < IP_MIN_HDR) begin
      chk_nxt.reason = RSN_SHORT;
    end else if ({10'd0, hlen} < IP_MIN_HDR) begin
      chk_nxt.reason = RSN_HDRLEN;
    end else if (snap.total_len < {10'd0, hlen}) begin
      chk_nxt.reason = RSN_TOTLEN;
    end else if (snap.count < {9'd0, hlen_udp}) begin
      chk_nxt.reason = RSN_TRUNC;
    end else if (snap.hsum != SUM_ONES) begin
      chk_nxt.reason = RSN_IPSUM;
    end else if (snap.proto != PROTO_UDP) begin
      chk_nxt.reason = RSN_PROTO;
    end else if (snap.udp_len < UDP_HDR_LEN) begin
      chk_nxt.reason = RSN_UDPLEN;
    end else if (snap.dport != local_port) begin
      chk_nxt.reason = RSN_PORT;
    end else if (snap.frag[13:0] != 14'd0) begin
      chk_nxt.reason = RSN_FRAG;
    end else if ({1'b0, snap.count} < udp_end) begin
      chk_nxt.reason = RSN_TRUNC;
    end else begin
      chk_nxt.reason = RSN_GOOD;
    end
  end

  // Stage valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_v_r <= 1'b0;
    end else if (snap_ready) begin
      chk_v_r <= snap_valid;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (snap_valid && snap_ready) begin
      chk_r <= chk_nxt;
    end
  end

  assign chk_valid = chk_v_r;
  assign chk       = chk_r;

endmodule

// ----- hdl/ipuv_result.sv -----
// Result stage: closes the UDP checksum, zeroes the fields of rejected
// packets and holds the verdict in the output register.
// Depends on ipuv_pkg and ipuv_if.
module ipuv_result
  import ipuv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       chk_valid,
  output logic       chk_ready,
  input  chk_res_t   chk,
  ipuv_out_if.source out_chan
);

  out_res_t    out_r;
  out_res_t    out_nxt;
  logic        out_v_r;
  logic [15:0] udp_sum;
  reason_t     final_reason;

  assign chk_ready = !out_v_r || out_chan.ready;
  assign udp_sum   = oc_add(chk.part_a, chk.part_b);

  // Last check, then zero the fields unless the packet passed.
  always_comb begin
    final_reason = chk.reason;
    if (chk.reason == RSN_GOOD && chk.sum_present && udp_sum != SUM_ONES) begin
      final_reason = RSN_UDPSUM;
    end
    out_nxt        = '0;
    out_nxt.reason = final_reason;
    if (final_reason == RSN_GOOD) begin
      out_nxt.accepted       = 1'b1;
      out_nxt.payload_length = chk.payload_length;
      out_nxt.payload_offset = chk.payload_offset;
      out_nxt.dest_addr      = chk.dest_addr;
      out_nxt.src_addr       = chk.src_addr;
      out_nxt.src_port       = chk.src_port;
    end
  end

  // Output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (chk_ready) begin
      out_v_r <= chk_valid;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (chk_valid && chk_ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid          = out_v_r;
  assign out_chan.accepted       = out_r.accepted;
  assign out_chan.reason         = out_r.reason;
  assign out_chan.payload_length = out_r.payload_length;
  assign out_chan.payload_offset = out_r.payload_offset;
  assign out_chan.dest_addr      = out_r.dest_addr;
  assign out_chan.src_addr       = out_r.src_addr;
  assign out_chan.src_port       = out_r.src_port;

endmodule

// ----- hdl/ipv4_udp_packet_validator.sv -----
// IPv4/UDP packet validator. One byte is taken per cycle with no gaps needed while
// the parser is not stalled; the verdict for a packet loads in turn into the snapshot,
// check and result registers, the snapshot on the edge that accepts its last byte.
// Each stage stalls only when the stage after it is full and not drained.
// Synchronous active-low reset clears the packet state, all stage valids and
// the local port register; the block takes bytes in the first cycle after reset.
module ipv4_udp_packet_validator
  import ipuv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ipuv_in_if.sink     in_chan,
  ipuv_out_if.source  out_chan,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] local_port_r;
  logic        snap_valid;
  logic        snap_ready;
  pkt_state_t  snap;
  logic        chk_valid;
  logic        chk_ready;
  chk_res_t    chk;

  // Local port register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_port_r <= '0;
    end else if (cfg_we) begin
      local_port_r <= cfg_wdata;
    end
  end

  ipuv_byte_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  ipuv_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .local_port (local_port_r),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap),
    .chk_valid  (chk_valid),
    .chk_ready  (chk_ready),
    .chk        (chk)
  );

  ipuv_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .chk_valid (chk_valid),
    .chk_ready (chk_ready),
    .chk       (chk),
    .out_chan  (out_chan)
  );

endmodule

// ----- hdl/ipuv_checker.sv -----
// Port-level checker for the packet validator, attached by a bind statement.
// Depends on ipuv_pkg and on ipv4_udp_packet_validator.
module ipuv_checker
  import ipuv_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        accepted,
  input logic [3:0]  reason,
  input logic [15:0] payload_length,
  input logic [6:0]  payload_offset,
  input logic [31:0] dest_addr,
  input logic [31:0] src_addr,
  input logic [15:0] src_port
);

  // A stalled verdict holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(reason) && $stable(accepted))
    else $error("verdict changed while stalled");

  // Accepted exactly when the reason is good.
  a_acc_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (accepted == (reason == RSN_GOOD)))
    else $error("accepted flag disagrees with reason");

  // A passing packet has a word-aligned data offset inside the legal range.
  a_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && accepted |->
      payload_offset >= 7'd28 && payload_offset <= 7'd68 && payload_offset[1:0] == 2'd0)
    else $error("payload offset out of range");

  // A rejected packet carries zero fields.
  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !accepted |->
      payload_length == 16'd0 && payload_offset == 7'd0 && dest_addr == 32'd0 &&
      src_addr == 32'd0 && src_port == 16'd0)
    else $error("rejected verdict carries nonzero fields");

  // Nothing is shown in the cycle after reset.
  a_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("verdict valid right after reset");

endmodule

bind ipv4_udp_packet_validator ipuv_checker u_ipuv_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .accepted       (out_chan.accepted),
  .reason         (out_chan.reason),
  .payload_length (out_chan.payload_length),
  .payload_offset (out_chan.payload_offset),
  .dest_addr      (out_chan.dest_addr),
  .src_addr       (out_chan.src_addr),
  .src_port       (out_chan.src_port)
);
